// ===== rtl/rpt_pkg.sv =====
// ----------------------------------------------------------------------------
// rpt_pkg
// Shared types, token kinds and character codes of the regex pattern
// tokenizer.
// ----------------------------------------------------------------------------
package rpt_pkg;

   localparam int unsigned POS_W               = 16;
   localparam int unsigned MAX_PATTERN_LEN_DEF = 65535;

   localparam logic [3:0] K_LIT     = 4'd0;
   localparam logic [3:0] K_DOT     = 4'd1;
   localparam logic [3:0] K_STAR    = 4'd2;
   localparam logic [3:0] K_ASTART  = 4'd3;
   localparam logic [3:0] K_AEND    = 4'd4;
   localparam logic [3:0] K_GOPEN   = 4'd5;
   localparam logic [3:0] K_GCLOSE  = 4'd6;
   localparam logic [3:0] K_BOPEN   = 4'd7;
   localparam logic [3:0] K_BCLOSE  = 4'd8;
   localparam logic [3:0] K_BRACKET = 4'd9;
   localparam logic [3:0] K_BACKREF = 4'd10;
   localparam logic [3:0] K_END     = 4'd11;
   localparam logic [3:0] K_ERR     = 4'd12;

   localparam logic [7:0] CH_CARET   = 8'h5E;
   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_ONE     = 8'h31;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_NONE    = 8'h00;

   typedef struct packed {
      logic [3:0]       kind;
      logic [7:0]       token_char;
      logic [POS_W-1:0] token_pos;
      logic [POS_W-1:0] bracket_len;
      logic             bracket_negated;
      logic             run_last;
   } token_type;

   function automatic token_type mk_tok(input logic [3:0]       kind,
                                        input logic [7:0]       ch,
                                        input logic [POS_W-1:0] pos,
                                        input logic [POS_W-1:0] len,
                                        input logic             neg);
      token_type t;
      t.kind            = kind;
      t.token_char      = ch;
      t.token_pos       = pos;
      t.bracket_len     = len;
      t.bracket_negated = neg;
      t.run_last        = 1'b0;
      return t;
   endfunction

endpackage

// ===== rtl/regex_pattern_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// regex_pattern_tokenizer_top
// Streaming tokenizer for basic regular expressions, one character a request.
//
// The req_ channel carries one pattern character per request, with tlast set
// on the final character of a pattern. The rsp_ channel returns the tokens
// that each character completes, zero to three of them, with tlast set on the
// last token belonging to that character. The kind of each token travels in
// tuser.
// A request is held in an input register and decoded into a three-slot
// result buffer, which drives the rsp_ ports directly. The first token of a
// request is on the rsp_ ports once the request has moved from the input
// register into the buffer. One request is taken every cycle as long as each
// yields at most one token and the receiver keeps up; otherwise the rate is
// set by the result buffer, which drains one token per cycle while the
// receiver is ready.
// When the receiver stalls, the buffer and then the input register fill and
// req_tready falls; nothing is dropped. Reset empties both and returns the
// scanner to the start of a pattern. After the final character the scanner
// also returns to that state, so the next request opens a new pattern.
// ----------------------------------------------------------------------------
module regex_pattern_tokenizer_top
   import rpt_pkg::*;
#(
   parameter int unsigned MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // char_in[7:0]
   input  logic        req_tlast,  // final_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // token_char[7:0], token_pos[23:8],
                                   // bracket_len[39:24], bracket_negated[40],
                                   // zero padding[47:41]
   output logic [3:0]  rsp_tuser,  // kind[3:0]
   output logic        rsp_tlast   // run_last
);

   localparam logic [POS_W-1:0] MAX_POS = MAX_PATTERN_LEN[POS_W-1:0];

   localparam logic [2:0] M_NORMAL   = 3'd0;
   localparam logic [2:0] M_ESC      = 3'd1;
   localparam logic [2:0] M_DOL      = 3'd2;
   localparam logic [2:0] M_DOLESC   = 3'd3;
   localparam logic [2:0] M_BR_FIRST = 3'd4;
   localparam logic [2:0] M_BR_CARET = 3'd5;
   localparam logic [2:0] M_BR_BODY  = 3'd6;

   logic             in_valid_ff;
   logic [7:0]       in_char_ff;
   logic             in_fin_ff;

   logic [2:0]       mode_ff, mode_in;
   logic             ags_ff, ags_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] held_ff, held_in;
   logic             neg_ff, neg_in;
   logic [POS_W-1:0] dpos_ff, dpos_in;

   token_type        tok_ff [3];
   token_type        tok_in [3];
   logic [1:0]       cnt_ff;
   logic [1:0]       n_in;

   logic             move;
   logic             pop;
   logic             esc_run;
   logic             norm_run;
   logic [POS_W:0]   blen_wide;
   logic [POS_W-1:0] blen;
   logic [POS_W-1:0] end_pos;

   assign pop        = (cnt_ff != 2'd0) && rsp_tready;
   assign move       = in_valid_ff && ((cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_tready));
   assign req_tready = !in_valid_ff || move;

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {7'd0, tok_ff[0].bracket_negated, tok_ff[0].bracket_len,
                        tok_ff[0].token_pos, tok_ff[0].token_char};
   assign rsp_tuser  = tok_ff[0].kind;
   assign rsp_tlast  = tok_ff[0].run_last;

   always_comb begin
      blen_wide = {1'b0, pos_ff} - {1'b0, held_ff} + {{POS_W{1'b0}}, 1'b1};
      if (pos_ff < held_ff) begin
         blen = {{(POS_W-1){1'b0}}, 1'b1};
      end else if (blen_wide[POS_W]) begin
         blen = {POS_W{1'b1}};
      end else begin
         blen = blen_wide[POS_W-1:0];
      end
      end_pos = (pos_ff < MAX_POS) ? pos_ff + {{(POS_W-1){1'b0}}, 1'b1} : MAX_POS;
   end

   always_comb begin
      mode_in  = mode_ff;
      ags_in   = ags_ff;
      pos_in   = pos_ff;
      held_in  = held_ff;
      neg_in   = neg_ff;
      dpos_in  = dpos_ff;
      n_in     = 2'd0;
      esc_run  = 1'b0;
      norm_run = 1'b0;
      for (int i = 0; i < 3; i++) begin
         tok_in[i] = '0;
      end

      case (mode_ff)
         M_ESC: begin
            esc_run = 1'b1;
         end
         M_DOL: begin
            if (in_char_ff == CH_BSLASH) begin
               if (in_fin_ff) begin
                  tok_in[n_in] = mk_tok(K_LIT, CH_DOLLAR, dpos_ff, '0, 1'b0);
                  n_in = n_in + 2'd1;
                  tok_in[n_in] = mk_tok(K_ERR, CH_NONE, pos_ff, '0, 1'b0);
                  n_in = n_in + 2'd1;
                  mode_in = M_NORMAL;
               end else begin
                  mode_in = M_DOLESC;
                  held_in = pos_ff;
               end
            end else begin
               tok_in[n_in] = mk_tok(K_LIT, CH_DOLLAR, dpos_ff, '0, 1'b0);
               n_in = n_in + 2'd1;
               ags_in   = 1'b0;
               norm_run = 1'b1;
            end
         end
         M_DOLESC: begin
            if (in_char_ff == CH_RPAREN) begin
               tok_in[n_in] = mk_tok(K_AEND, CH_NONE, dpos_ff, '0, 1'b0);
               n_in = n_in + 2'd1;
               tok_in[n_in] = mk_tok(K_GCLOSE, CH_NONE, held_ff, '0, 1'b0);
               n_in = n_in + 2'd1;
               ags_in  = 1'b0;
               mode_in = M_NORMAL;
            end else begin
               tok_in[n_in] = mk_tok(K_LIT, CH_DOLLAR, dpos_ff, '0, 1'b0);
               n_in = n_in + 2'd1;
               esc_run = 1'b1;
            end
         end
         M_BR_FIRST: begin
            if (in_char_ff == CH_CARET) begin
               neg_in  = 1'b1;
               mode_in = M_BR_CARET;
            end else begin
               mode_in = M_BR_BODY;
            end
         end
         M_BR_CARET: begin
            mode_in = M_BR_BODY;
         end
         M_BR_BODY: begin
            if (in_char_ff == CH_RBRACK) begin
               tok_in[n_in] = mk_tok(K_BRACKET, CH_NONE, held_ff, blen, neg_ff);
               n_in = n_in + 2'd1;
               ags_in  = 1'b0;
               mode_in = M_NORMAL;
            end
         end
         default: begin
            norm_run = 1'b1;
         end
      endcase

      if (esc_run) begin
         case (in_char_ff)
            CH_LPAREN: tok_in[n_in] = mk_tok(K_GOPEN, CH_NONE, held_ff, '0, 1'b0);
            CH_RPAREN: tok_in[n_in] = mk_tok(K_GCLOSE, CH_NONE, held_ff, '0, 1'b0);
            CH_LBRACE: tok_in[n_in] = mk_tok(K_BOPEN, CH_NONE, held_ff, '0, 1'b0);
            CH_RBRACE: tok_in[n_in] = mk_tok(K_BCLOSE, CH_NONE, held_ff, '0, 1'b0);
            default: begin
               if (in_char_ff inside {[CH_ONE:CH_NINE]}) begin
                  tok_in[n_in] = mk_tok(K_BACKREF, in_char_ff, held_ff, '0, 1'b0);
               end else begin
                  tok_in[n_in] = mk_tok(K_LIT, in_char_ff, held_ff, '0, 1'b0);
               end
            end
         endcase
         n_in    = n_in + 2'd1;
         ags_in  = (in_char_ff == CH_LPAREN);
         mode_in = M_NORMAL;
      end

      if (norm_run) begin
         mode_in = M_NORMAL;
         case (in_char_ff)
            CH_CARET: begin
               if (ags_in) begin
                  tok_in[n_in] = mk_tok(K_ASTART, CH_NONE, pos_ff, '0, 1'b0);
               end else begin
                  tok_in[n_in] = mk_tok(K_LIT, CH_CARET, pos_ff, '0, 1'b0);
               end
               n_in   = n_in + 2'd1;
               ags_in = 1'b0;
            end
            CH_DOLLAR: begin
               if (in_fin_ff) begin
                  tok_in[n_in] = mk_tok(K_AEND, CH_NONE, pos_ff, '0, 1'b0);
                  n_in = n_in + 2'd1;
               end else begin
                  mode_in = M_DOL;
                  dpos_in = pos_ff;
               end
               ags_in = 1'b0;
            end
            CH_DOT: begin
               tok_in[n_in] = mk_tok(K_DOT, CH_NONE, pos_ff, '0, 1'b0);
               n_in   = n_in + 2'd1;
               ags_in = 1'b0;
            end
            CH_STAR: begin
               tok_in[n_in] = mk_tok(K_STAR, CH_NONE, pos_ff, '0, 1'b0);
               n_in   = n_in + 2'd1;
               ags_in = 1'b0;
            end
            CH_LBRACK: begin
               mode_in = M_BR_FIRST;
               held_in = pos_ff;
               neg_in  = 1'b0;
               ags_in  = 1'b0;
            end
            CH_BSLASH: begin
               mode_in = M_ESC;
               held_in = pos_ff;
            end
            default: begin
               tok_in[n_in] = mk_tok(K_LIT, in_char_ff, pos_ff, '0, 1'b0);
               n_in   = n_in + 2'd1;
               ags_in = 1'b0;
            end
         endcase
      end

      if (in_fin_ff) begin
         if (mode_in inside {M_ESC, M_BR_FIRST, M_BR_CARET, M_BR_BODY}) begin
            tok_in[n_in] = mk_tok(K_ERR, CH_NONE, held_in, '0, 1'b0);
            n_in = n_in + 2'd1;
         end
         tok_in[n_in] = mk_tok(K_END, CH_NONE, end_pos, '0, 1'b0);
         n_in = n_in + 2'd1;
         mode_in = M_NORMAL;
         ags_in  = 1'b1;
         pos_in  = '0;
         held_in = '0;
         neg_in  = 1'b0;
         dpos_in = '0;
      end else if (pos_ff < MAX_POS) begin
         pos_in = pos_ff + {{(POS_W-1){1'b0}}, 1'b1};
      end

      if (n_in != 2'd0) begin
         tok_in[n_in - 2'd1].run_last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         cnt_ff      <= 2'd0;
         mode_ff     <= M_NORMAL;
         ags_ff      <= 1'b1;
         pos_ff      <= '0;
         held_ff     <= '0;
         neg_ff      <= 1'b0;
         dpos_ff     <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (move) begin
            in_valid_ff <= 1'b0;
         end
         if (move) begin
            cnt_ff  <= n_in;
            mode_ff <= mode_in;
            ags_ff  <= ags_in;
            pos_ff  <= pos_in;
            held_ff <= held_in;
            neg_ff  <= neg_in;
            dpos_ff <= dpos_in;
         end else if (pop) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_fin_ff  <= req_tlast;
      end
      if (move) begin
         tok_ff[0] <= tok_in[0];
         tok_ff[1] <= tok_in[1];
         tok_ff[2] <= tok_in[2];
      end else if (pop) begin
         tok_ff[0] <= tok_ff[1];
         tok_ff[1] <= tok_ff[2];
      end
   end

   // The newest token in the buffer always closes the run of its request.
   a_last_closes_run: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != 2'd0) |-> tok_ff[cnt_ff - 2'd1].run_last)
      else $error("buffered run does not end with a last token");

   // A final character always produces an end token as its last result.
   a_final_ends: assert property (@(posedge clock) disable iff (reset)
      (move && in_fin_ff) |-> ((n_in != 2'd0) && (tok_in[n_in - 2'd1].kind == K_END)))
      else $error("final character without end token");

   // After a final character the scanner is back at the start of a pattern.
   a_final_resets: assert property (@(posedge clock) disable iff (reset)
      (move && in_fin_ff) |=> ((mode_ff == M_NORMAL) && ags_ff && (pos_ff == '0)))
      else $error("scanner not returned to pattern start");

   // A request only leaves the input register when the buffer is empty or its last token is being taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      move |-> ((cnt_ff == 2'd0) || pop))
      else $error("buffer overwritten while tokens are pending");

   // The position counter never passes its saturation point.
   a_pos_sat: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= MAX_POS)
      else $error("pattern position beyond limit");

endmodule
